// ===== src/slasb_pkg.sv =====
// ----------------------------------------------------------------------------
// slasb_pkg
// shared codes, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package slasb_pkg;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_STOP = 8'h21;

    localparam logic [1:0] OP_BYTE     = 2'd0;
    localparam logic [1:0] OP_TAKE_STP = 2'd1;
    localparam logic [1:0] OP_TAKE_OVF = 2'd2;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;
    localparam logic [1:0] KIND_OVF  = 2'd3;

    localparam logic [7:0] CAP_RESET = 8'd64;

    typedef struct packed {
        logic store;
        logic overflow;
        logic set_stop;
        logic clr_line;
        logic take_latch;
        logic start_rd;
        logic rd;
        logic emit_char;
        logic emit_end;
        logic emit_flag;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic op_byte;
        logic op_take;
        logic is_stop;
        logic is_cr;
        logic is_lf;
        logic discard;
        logic len_zero;
        logic len_ge_cap;
        logic len_full;
        logic out_free;
        logic idx_last;
    } t_sts;

endpackage

// ===== src/slasb_ram.sv =====
// ----------------------------------------------------------------------------
// slasb_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module slasb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/slasb_ctrl.sv =====
// ----------------------------------------------------------------------------
// slasb_ctrl
// controller: decodes accepted items and sequences line readout
// ----------------------------------------------------------------------------
module slasb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  slasb_pkg::t_sts  i_sts,
    output slasb_pkg::t_cmd  o_cmd,
    output logic             o_in_stall
);
    import slasb_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FLAG = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_CHAR = 3'd3;
    localparam logic [2:0] S_END  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid) begin
                    if (i_sts.op_take) begin
                        cmd.take_latch = 1'b1;
                        n_state        = S_FLAG;
                    end else if (i_sts.op_byte) begin
                        if (i_sts.is_stop) begin
                            cmd.set_stop = 1'b1;
                        end else if (i_sts.is_cr) begin
                            cmd = '0;
                        end else if (i_sts.is_lf) begin
                            if (i_sts.discard || i_sts.len_ge_cap) begin
                                cmd.clr_line = 1'b1;
                            end else if (i_sts.len_zero) begin
                                n_state = S_END;
                            end else begin
                                cmd.start_rd = 1'b1;
                                n_state      = S_READ;
                            end
                        end else if (!i_sts.discard) begin
                            if (i_sts.len_full) begin
                                cmd.overflow = 1'b1;
                            end else begin
                                cmd.store = 1'b1;
                            end
                        end
                    end
                end
            end
            S_FLAG: begin
                if (i_sts.out_free) begin
                    cmd.emit_flag = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_READ: begin
                cmd.rd  = 1'b1;
                n_state = S_CHAR;
            end
            S_CHAR: begin
                if (i_sts.out_free) begin
                    cmd.emit_char = 1'b1;
                    n_state       = i_sts.idx_last ? S_END : S_READ;
                end
            end
            S_END: begin
                if (i_sts.out_free) begin
                    cmd.emit_end = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== src/slasb_dp.sv =====
// ----------------------------------------------------------------------------
// slasb_dp
// datapath: line store, length, flags, capacity register and output register
// ----------------------------------------------------------------------------
module slasb_dp #(
    parameter int LINE_SIZE = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  slasb_pkg::t_cmd  i_cmd,
    output slasb_pkg::t_sts  o_sts,
    input  logic             i_in_valid,
    input  logic [1:0]       i_opcode,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_char_out,
    output logic             o_flag_out,
    output logic             o_last
);
    import slasb_pkg::*;

    localparam int LW    = $clog2(LINE_SIZE);
    localparam int DEPTH = LINE_SIZE - 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [LW-1:0] r_len;
    logic [LW-1:0] r_idx;
    logic          r_discard;
    logic          r_stop;
    logic          r_ovf;
    logic          r_take_ovf;
    logic [7:0]    r_cap;
    logic          r_out_valid;
    logic [1:0]    r_kind;
    logic [7:0]    r_char;
    logic          r_flag;
    logic          r_last;
    logic [7:0]    ram_rdata;
    logic          out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    slasb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_sts            = '0;
        o_sts.in_valid   = i_in_valid;
        o_sts.op_byte    = (i_opcode == OP_BYTE);
        o_sts.op_take    = (i_opcode == OP_TAKE_STP) || (i_opcode == OP_TAKE_OVF);
        o_sts.is_stop    = (i_rx_byte == CH_STOP);
        o_sts.is_cr      = (i_rx_byte == CH_CR);
        o_sts.is_lf      = (i_rx_byte == CH_LF);
        o_sts.discard    = r_discard;
        o_sts.len_zero   = (r_len == '0);
        o_sts.len_ge_cap = (9'(r_len) >= 9'(r_cap));
        o_sts.len_full   = (r_len == LW'(DEPTH));
        o_sts.out_free   = out_free;
        o_sts.idx_last   = (LW'(r_idx + 1'b1) == r_len);
    end

    // line length, discard state, flags and capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_discard <= 1'b0;
            r_stop    <= 1'b0;
            r_ovf     <= 1'b0;
            r_cap     <= CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.store) begin
                r_len <= LW'(r_len + 1'b1);
            end
            if (i_cmd.overflow) begin
                r_len     <= '0;
                r_discard <= 1'b1;
                r_ovf     <= 1'b1;
            end
            if (i_cmd.clr_line || i_cmd.emit_end) begin
                r_len     <= '0;
                r_discard <= 1'b0;
            end
            if (i_cmd.set_stop) begin
                r_stop <= 1'b1;
            end
            if (i_cmd.emit_flag) begin
                if (r_take_ovf) begin
                    r_ovf <= 1'b0;
                end else begin
                    r_stop <= 1'b0;
                end
            end
        end
    end

    // readout index and pending flag query
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_latch) begin
            r_take_ovf <= (i_opcode == OP_TAKE_OVF);
        end
        if (i_cmd.start_rd) begin
            r_idx <= '0;
        end else if (i_cmd.emit_char) begin
            r_idx <= LW'(r_idx + 1'b1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_char || i_cmd.emit_end || i_cmd.emit_flag) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_char) begin
            r_kind <= KIND_CHAR;
            r_char <= ram_rdata;
            r_flag <= 1'b0;
            r_last <= 1'b0;
        end else if (i_cmd.emit_end) begin
            r_kind <= KIND_END;
            r_char <= '0;
            r_flag <= 1'b0;
            r_last <= 1'b1;
        end else if (i_cmd.emit_flag) begin
            r_kind <= r_take_ovf ? KIND_OVF : KIND_STOP;
            r_char <= '0;
            r_flag <= r_take_ovf ? r_ovf : r_stop;
            r_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_char_out  = r_char;
    assign o_flag_out  = r_flag;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    a_discard_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discard |-> (r_len == '0))
        else $error("line not empty while discarding");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_char || i_cmd.emit_end || i_cmd.emit_flag) |-> out_free)
        else $error("output register loaded while holding a stalled result");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_end |=> (r_out_valid && r_last && (r_kind == KIND_END)))
        else $error("end of line result not marked last");

    a_char_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (r_idx < r_len))
        else $error("readout past end of line");
`endif

endmodule

// ===== src/serial_line_assembler_with_stop_byte_unit.sv =====
// ----------------------------------------------------------------------------
// serial_line_assembler_with_stop_byte_unit
// builds text lines from received serial bytes, with stop and overflow flags
// ----------------------------------------------------------------------------
// A received byte, carriage return, stop byte, unused opcode or a line feed
// that drops the line is taken without a stall. A flag query returns one
// result and stalls the input until it is loaded. For a line feed that
// emits a line, each character is one registered read of the line store
// followed by a load of the output register, and the input stalls until
// the end-of-line result is in the output register. The output register
// lets the next item be accepted while the final result waits to be taken.
// ----------------------------------------------------------------------------
module serial_line_assembler_with_stop_byte_unit #(
    parameter int LINE_SIZE = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_char_out,
    output logic       o_flag_out,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    import slasb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    slasb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    slasb_dp #(
        .LINE_SIZE (LINE_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_char_out  (o_char_out),
        .o_flag_out  (o_flag_out),
        .o_last      (o_last)
    );

endmodule

// ===== test/serial_line_assembler_with_stop_byte_unit_tb.sv =====
// ----------------------------------------------------------------------------
// serial_line_assembler_with_stop_byte_unit_tb
// self-checking bench: directed and random byte streams, flag queries and
// capacity changes, with random gaps and stalls on both channels; every
// output transfer is compared with a line-tracking prediction of the block
// ----------------------------------------------------------------------------
module serial_line_assembler_with_stop_byte_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import slasb_pkg::*;

    localparam int LINE_SIZE = 64;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] char_out;
        logic       flag_out;
        logic       last;
    } t_line_result;

    class t_line_tracker;
        logic [7:0]   capacity;
        logic [7:0]   store [LINE_SIZE-1];
        int           line_len;
        bit           discarding;
        bit           stop_flag;
        bit           ovf_flag;
        t_line_result pending_results[$];
        int           errors;

        function new();
            capacity   = CAP_RESET;
            line_len   = 0;
            discarding = 0;
            stop_flag  = 0;
            ovf_flag   = 0;
            errors     = 0;
        endfunction

        function void add_result(logic [1:0] kind, logic [7:0] ch, logic flag, logic last);
            t_line_result r;
            r.kind     = kind;
            r.char_out = ch;
            r.flag_out = flag;
            r.last     = last;
            pending_results.push_back(r);
        endfunction

        function void take_item(logic [1:0] op, logic [7:0] b);
            case (op)
                OP_TAKE_STP: begin
                    add_result(KIND_STOP, 8'd0, stop_flag, 1'b1);
                    stop_flag = 0;
                end
                OP_TAKE_OVF: begin
                    add_result(KIND_OVF, 8'd0, ovf_flag, 1'b1);
                    ovf_flag = 0;
                end
                OP_BYTE: begin
                    if (b == CH_STOP) begin
                        stop_flag = 1;
                    end else if (b == CH_CR) begin
                    end else if (b == CH_LF) begin
                        if (discarding) begin
                            discarding = 0;
                            line_len   = 0;
                        end else if (line_len >= capacity) begin
                            line_len = 0;
                        end else begin
                            for (int i = 0; i < line_len; i++)
                                add_result(KIND_CHAR, store[i], 1'b0, 1'b0);
                            add_result(KIND_END, 8'd0, 1'b0, 1'b1);
                            line_len = 0;
                        end
                    end else if (!discarding) begin
                        if (line_len < LINE_SIZE - 1) begin
                            store[line_len] = b;
                            line_len++;
                        end else begin
                            line_len   = 0;
                            discarding = 1;
                            ovf_flag   = 1;
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_output(logic [1:0] kind, logic [7:0] ch, logic flag, logic last);
            t_line_result e;
            if (pending_results.size() == 0) begin
                $error("unexpected output transfer: kind %0d char %0h flag %0d last %0d",
                       kind, ch, flag, last);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (kind !== e.kind) begin
                $error("kind: expected %0d, actual %0d", e.kind, kind);
                errors++;
            end
            if (ch !== e.char_out) begin
                $error("char_out: expected %0h, actual %0h", e.char_out, ch);
                errors++;
            end
            if (flag !== e.flag_out) begin
                $error("flag_out: expected %0d, actual %0d", e.flag_out, flag);
                errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d, actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_opcode;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [1:0] o_kind;
    logic [7:0] o_char_out;
    logic       o_flag_out;
    logic       o_last;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    t_line_tracker tracker = new();

    int items_offered = 0;
    int results_taken = 0;
    int burst_left    = 0;
    bit offer_dropped = 1;
    bit held_off      = 0;

    serial_line_assembler_with_stop_byte_unit #(
        .LINE_SIZE(LINE_SIZE)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_opcode   (i_opcode),
        .i_rx_byte  (i_rx_byte),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_kind     (o_kind),
        .o_char_out (o_char_out),
        .o_flag_out (o_flag_out),
        .o_last     (o_last),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_output(o_kind, o_char_out, o_flag_out, o_last);
            results_taken++;
        end
    end

    // output side: random stalls, calm stretches and one long hold-off
    initial begin
        int stall_left;
        int calm_left;
        int r;
        stall_left = 0;
        calm_left  = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_off && results_taken >= 30) begin
                held_off = 1;
                i_out_stall <= 1'b1;
                repeat (250) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (calm_left > 0) begin
                i_out_stall <= 1'b0;
                calm_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    calm_left = $urandom_range(30, 120);
                else if (r < 30)
                    stall_left = $urandom_range(1, 3);
                else if (r < 33)
                    stall_left = $urandom_range(10, 25);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(logic [1:0] op, logic [7:0] b);
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_rx_byte  <= b;
        offer_dropped = 0;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_item(op, b);
        items_offered++;
    endtask

    task automatic random_pause();
        int r;
        int gap;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3)
                burst_left = $urandom_range(20, 60);
            else if (r < 60)
                gap = 0;
            else if (r < 90)
                gap = $urandom_range(1, 3);
            else if (r < 97)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 40);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            offer_dropped = 1;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic offer_byte(logic [7:0] b);
        send_item(OP_BYTE, b);
        random_pause();
    endtask

    function automatic logic [7:0] pick_line_byte(bit plain);
        logic [7:0] b;
        int r;
        r = plain ? 99 : $urandom_range(0, 19);
        if (r == 0)
            return CH_STOP;
        if (r == 1)
            return CH_CR;
        do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
        return b;
    endfunction

    task automatic send_chars(int n, bit plain);
        for (int i = 0; i < n; i++) begin
            if (!plain && $urandom_range(0, 39) == 0) begin
                send_item($urandom_range(0, 1) ? OP_TAKE_STP : OP_TAKE_OVF, 8'($urandom));
                random_pause();
            end
            offer_byte(pick_line_byte(plain));
        end
    endtask

    task automatic random_traffic(int budget);
        int start;
        int r;
        int n;
        start = items_offered;
        while (items_offered - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_item($urandom_range(0, 1) ? OP_TAKE_STP : OP_TAKE_OVF, 8'($urandom));
                random_pause();
            end else if (r < 11) begin
                send_item(OP_UNUSED, 8'($urandom));
                random_pause();
            end else if (r < 13) begin
                offer_byte(CH_LF);
            end else if (r < 15) begin
                offer_byte(8'($urandom));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    n = $urandom_range(0, 6);
                else if (r < 90)
                    n = $urandom_range(7, 24);
                else if (r < 97)
                    n = $urandom_range(25, 62);
                else
                    n = $urandom_range(63, 68);
                send_chars(n, 0);
                offer_byte(CH_LF);
            end
        end
    endtask

    task automatic wait_for_quiet();
        if (!offer_dropped) begin
            i_in_valid <= 1'b0;
            offer_dropped = 1;
        end
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [7:0] cap);
        wait_for_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.capacity = cap;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_opcode    <= OP_BYTE;
        i_rx_byte   <= 8'd0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 8'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // flags clear after reset, empty line, unused opcode, stop byte
        send_item(OP_TAKE_STP, 8'h00);
        send_item(OP_TAKE_OVF, 8'hFF);
        offer_byte(CH_LF);
        send_item(OP_UNUSED, 8'hFF);
        offer_byte(CH_STOP);
        send_item(OP_TAKE_STP, 8'h00);
        send_item(OP_TAKE_STP, 8'h00);
        offer_byte(8'h00);
        offer_byte(8'hFF);
        offer_byte(CH_CR);
        offer_byte(8'h41);
        offer_byte(CH_STOP);
        offer_byte(8'h80);
        offer_byte(CH_LF);
        send_item(OP_TAKE_STP, 8'h00);
        random_pause();

        // line at capacity is dropped, shorter ones pass
        write_capacity(8'd3);
        send_chars(3, 1);
        offer_byte(CH_LF);
        send_chars(2, 1);
        offer_byte(CH_LF);
        offer_byte(CH_LF);

        // full store emitted, then overflow with a stop byte while discarding
        write_capacity(8'd64);
        send_chars(LINE_SIZE - 1, 1);
        offer_byte(CH_LF);
        send_chars(LINE_SIZE, 1);
        offer_byte(CH_STOP);
        send_chars(2, 1);
        offer_byte(CH_LF);
        send_item(OP_TAKE_OVF, 8'h00);
        send_item(OP_TAKE_OVF, 8'h00);
        send_item(OP_TAKE_STP, 8'h00);
        random_pause();
        random_traffic(20);

        write_capacity(8'd255);
        random_traffic(25);
        write_capacity(8'd1);
        random_traffic(20);
        write_capacity(8'($urandom_range(2, 254)));
        random_traffic(20);
        write_capacity(8'd63);
        random_traffic(15);

        wait_for_quiet();
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
